@@ rtl/core/hsv_value_replace_defines.svh @@
// assertion macros for the hsv value replace block
`ifndef HSV_VALUE_REPLACE_DEFINES_SVH
`define HSV_VALUE_REPLACE_DEFINES_SVH
`ifndef SYNTHESIS
`define HVR_ASSERT_NOW(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define HVR_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define HVR_ASSERT_NOW(label, clk, rst, a, c)
`define HVR_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ rtl/core/hvr_pkg.sv @@
// shared types and constants for the hsv value replace block
`timescale 1ns / 1ps
package hvr_pkg;

   typedef enum logic [2:0] {
      SEC0 = 3'd0,
      SEC1 = 3'd1,
      SEC2 = 3'd2,
      SEC3 = 3'd3,
      SEC4 = 3'd4,
      SEC5 = 3'd5
   } sector_type;

   typedef struct packed {
      logic [7:0] mx;
      logic [7:0] delta;
      logic [7:0] diff;
      logic [7:0] value;
      sector_type sector;
      logic       gray;
   } hvr_item_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;

   typedef struct packed {
      logic                valid;
      logic                full;
      logic [QUEUE_AW:0]   count;
   } hvr_qstat_type;

endpackage

@@ rtl/core/hvr_front.sv @@
// front part: max/min, hue sector and in-sector position of a request
`timescale 1ns / 1ps
module hvr_front
   import hvr_pkg::*;
(
   input  logic [7:0]   red_in,
   input  logic [7:0]   green_in,
   input  logic [7:0]   blue_in,
   input  logic [7:0]   target_value,
   output hvr_item_type item
);

   logic [7:0] mx, mn, delta;

   always_comb begin
      mx = red_in;
      if (green_in > mx) mx = green_in;
      if (blue_in > mx) mx = blue_in;
      mn = red_in;
      if (green_in < mn) mn = green_in;
      if (blue_in < mn) mn = blue_in;
      delta = mx - mn;

      item.mx = mx;
      item.delta = delta;
      item.value = target_value;
      item.gray = (delta == 8'd0);
      // ties for the max go to red, then green
      if (red_in == mx) begin
         if (green_in >= blue_in) begin
            item.sector = SEC0;
            item.diff = green_in - blue_in;
         end else begin
            item.sector = SEC5;
            item.diff = delta - (blue_in - green_in);
         end
      end else if (green_in == mx) begin
         if (blue_in >= red_in) begin
            item.sector = SEC2;
            item.diff = blue_in - red_in;
         end else begin
            item.sector = SEC1;
            item.diff = delta - (red_in - blue_in);
         end
      end else begin
         if (red_in >= green_in) begin
            item.sector = SEC4;
            item.diff = red_in - green_in;
         end else begin
            item.sector = SEC3;
            item.diff = delta - (green_in - red_in);
         end
      end
   end

endmodule

@@ rtl/core/hvr_queue.sv @@
// short queue between the front and back parts
`timescale 1ns / 1ps
module hvr_queue
   import hvr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  hvr_item_type  push_item,
   input  logic          pop,
   output hvr_item_type  head_item,
   output hvr_qstat_type stat
);

   hvr_item_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      stat.count = count_ff;
      stat.valid = (count_ff != '0);
      stat.full = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
      do_push = push && !stat.full;
      do_pop = pop && stat.valid;
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
      head_item = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_item;
   end

endmodule

@@ rtl/core/hvr_back.sv @@
// back part: pipelined dividers, hsv to rgb scaling and the result register
`timescale 1ns / 1ps
module hvr_back
   import hvr_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  hvr_item_type head_item,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   red_out,
   output logic [7:0]   green_out,
   output logic [7:0]   blue_out
);

   localparam int NS = FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic               en;

   // one quotient bit per divider stage
   logic [7:0]         rs_ff [NS];
   logic [7:0]         rf_ff [NS];
   logic [FRAC_BITS:0] qs_ff [NS];
   logic [FRAC_BITS:0] qf_ff [NS];
   hvr_item_type       it_ff [NS];
   logic               vld_ff [NS];
   logic [7:0]         rs_in [NS];
   logic [7:0]         rf_in [NS];
   logic [FRAC_BITS:0] qs_in [NS];
   logic [FRAC_BITS:0] qf_in [NS];
   hvr_item_type       it_in [NS];
   logic               vld_in [NS];

   logic [2*FRAC_BITS+1:0] prod_sf, prod_sg;
   logic [FRAC_BITS:0]     s_val, f_val, g_val;
   logic [FRAC_BITS:0]     t1_ff, t2_ff, t3_ff, t1_in, t2_in, t3_in;
   hvr_item_type           it1_ff, it2_ff;
   logic                   vld1_ff, vld2_ff;
   logic [FRAC_BITS+8:0]   p1, p2, p3;
   logic [7:0]             c1_ff, c2_ff, c3_ff;
   logic [7:0]             ro_in, go_in, bo_in;

   assign en = !rsp_valid || !rsp_stall;
   assign pop = en;

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         logic [8:0] ts, tf;
         logic       bs, bf;
         if (i == 0) begin
            it_in[i] = head_item;
            vld_in[i] = head_valid;
            ts = {1'b0, head_item.delta};
            tf = {1'b0, head_item.diff};
         end else begin
            it_in[i] = it_ff[i-1];
            vld_in[i] = vld_ff[i-1];
            ts = {rs_ff[i-1], 1'b0};
            tf = {rf_ff[i-1], 1'b0};
         end
         bs = (ts >= {1'b0, it_in[i].mx});
         bf = (tf >= {1'b0, it_in[i].delta});
         rs_in[i] = bs ? 8'(ts - {1'b0, it_in[i].mx}) : ts[7:0];
         rf_in[i] = bf ? 8'(tf - {1'b0, it_in[i].delta}) : tf[7:0];
         if (i == 0) begin
            qs_in[i] = {{FRAC_BITS{1'b0}}, bs};
            qf_in[i] = {{FRAC_BITS{1'b0}}, bf};
         end else begin
            qs_in[i] = {qs_ff[i-1][FRAC_BITS-1:0], bs};
            qf_in[i] = {qf_ff[i-1][FRAC_BITS-1:0], bf};
         end
      end
   end

   always_comb begin
      s_val = qs_ff[NS-1];
      f_val = qf_ff[NS-1];
      g_val = ONE - f_val;
      prod_sf = s_val * f_val;
      prod_sg = s_val * g_val;
      t1_in = ONE - s_val;
      t2_in = ONE - prod_sf[2*FRAC_BITS:FRAC_BITS];
      t3_in = ONE - prod_sg[2*FRAC_BITS:FRAC_BITS];
      p1 = it1_ff.value * t1_ff;
      p2 = it1_ff.value * t2_ff;
      p3 = it1_ff.value * t3_ff;
   end

   always_comb begin
      case (it2_ff.sector)
         SEC0: begin ro_in = it2_ff.value; go_in = c3_ff; bo_in = c1_ff; end
         SEC1: begin ro_in = c2_ff; go_in = it2_ff.value; bo_in = c1_ff; end
         SEC2: begin ro_in = c1_ff; go_in = it2_ff.value; bo_in = c3_ff; end
         SEC3: begin ro_in = c1_ff; go_in = c2_ff; bo_in = it2_ff.value; end
         SEC4: begin ro_in = c3_ff; go_in = c1_ff; bo_in = it2_ff.value; end
         default: begin ro_in = it2_ff.value; go_in = c1_ff; bo_in = c2_ff; end
      endcase
      if (it2_ff.gray) begin
         ro_in = it2_ff.value;
         go_in = it2_ff.value;
         bo_in = it2_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) vld_ff[i] <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < NS; i++) vld_ff[i] <= vld_in[i];
         vld1_ff <= vld_ff[NS-1];
         vld2_ff <= vld1_ff;
         rsp_valid <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NS; i++) begin
            rs_ff[i] <= rs_in[i];
            rf_ff[i] <= rf_in[i];
            qs_ff[i] <= qs_in[i];
            qf_ff[i] <= qf_in[i];
            it_ff[i] <= it_in[i];
         end
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         t3_ff <= t3_in;
         it1_ff <= it_ff[NS-1];
         c1_ff <= p1[FRAC_BITS+7:FRAC_BITS];
         c2_ff <= p2[FRAC_BITS+7:FRAC_BITS];
         c3_ff <= p3[FRAC_BITS+7:FRAC_BITS];
         it2_ff <= it1_ff;
         red_out <= ro_in;
         green_out <= go_in;
         blue_out <= bo_in;
      end
   end

endmodule

@@ rtl/core/hsv_value_replace.sv @@
// Replaces the HSV value of an RGB pixel while keeping hue and saturation.
// One pixel per clock is sustained while the result is not stalled. A
// request passes the classifier and a four-entry queue, then FRAC_BITS+1
// divider stages (one quotient bit each, computing saturation and the
// in-sector fraction side by side), one stage for the fraction products,
// one for the value products and the result register.
// A stalled result freezes the back pipeline; the queue keeps taking
// requests until it is full.
`timescale 1ns / 1ps
`include "hsv_value_replace_defines.svh"
module hsv_value_replace
   import hvr_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   input  logic [7:0] req_target_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out
);

   hvr_item_type  front_item, head_item;
   hvr_qstat_type qstat;
   logic          pop;

   hvr_front u_front (
      .red_in       (req_red_in),
      .green_in     (req_green_in),
      .blue_in      (req_blue_in),
      .target_value (req_target_value),
      .item         (front_item)
   );

   hvr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (qstat)
   );

   assign req_stall = qstat.full;

   hvr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (qstat.valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .red_out    (rsp_red_out),
      .green_out  (rsp_green_out),
      .blue_out   (rsp_blue_out)
   );

   `HVR_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
                   qstat.count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
   `HVR_ASSERT_NEXT(a_queue_fills, clock, reset,
                    req_valid && !req_stall && !pop && qstat.count == '0,
                    qstat.count == (QUEUE_AW + 1)'(1))
   `HVR_ASSERT_NEXT(a_queue_drains, clock, reset,
                    pop && qstat.valid && !(req_valid && !req_stall),
                    qstat.count == $past(qstat.count) - 1'b1)

endmodule

@@ tb/hsv_value_replace_tb.sv @@
// self-checking testbench for the hsv value replace block
`timescale 1ns / 1ps
module hsv_value_replace_tb
   import hvr_pkg::*;
();

   localparam int FB = 16;
   localparam int LATENCY = FB + 5;
   localparam int N_RANDOM = 1800;
   localparam int STUCK_LIMIT = 4000;
   localparam int N_DIRECTED = 20;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_red_in, req_green_in, req_blue_in, req_target_value;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;

   pixel_type pixel_q[$];
   int        n_mismatch;
   int        n_checked;
   int        n_sent;
   int        idle_cycles;
   bit        stim_done;

   // directed rows: r, g, b, v, fixed expectation, expected pixel
   logic [7:0] dir_r[N_DIRECTED]   = '{0,   255, 77,  255, 0,   0,   255, 255,
                                       0,   255, 255, 0,   1,   255, 200, 254,
                                       10,  255, 128, 1};
   logic [7:0] dir_g[N_DIRECTED]   = '{0,   255, 77,  0,   255, 0,   255, 0,
                                       255, 0,   255, 0,   0,   128, 200, 255,
                                       20,  0,   255, 2};
   logic [7:0] dir_b[N_DIRECTED]   = '{0,   255, 77,  0,   0,   255, 0,   255,
                                       255, 128, 255, 0,   0,   254, 10,  1,
                                       30,  255, 0,   3};
   logic [7:0] dir_v[N_DIRECTED]   = '{0,   255, 99,  255, 255, 255, 255, 255,
                                       255, 0,   128, 255, 255, 255, 77,  255,
                                       170, 1,   255, 200};
   bit         dir_fixed[N_DIRECTED] = '{1, 1, 1, 1, 1, 1, 1, 1,
                                        1, 1, 1, 1, 1, 0, 0, 0,
                                        0, 0, 0, 0};
   pixel_type  dir_exp[N_DIRECTED] = '{
      '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd99, 8'd99, 8'd99},
      '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255},
      '{8'd255, 8'd255, 8'd0}, '{8'd255, 8'd0, 8'd255}, '{8'd0, 8'd255, 8'd255},
      '{8'd0, 8'd0, 8'd0}, '{8'd128, 8'd128, 8'd128}, '{8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd0, 8'd0}, '0, '0, '0, '0, '0, '0, '0};

   hsv_value_replace #(.FRAC_BITS(FB)) uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] scale_value(logic [7:0] v, logic [FB:0] t);
      logic [FB+8:0] p;
      p = v * t;
      return p[FB+7:FB];
   endfunction

   function automatic pixel_type replace_value(logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b, logic [7:0] v);
      logic [7:0]   mx, mn, delta, diff;
      sector_type   sec;
      logic [FB:0]  s, f, t1, t2, t3;
      logic [2*FB+1:0] sf, sfn;
      logic [7:0]   c1, c2, c3;
      pixel_type    p;
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      delta = mx - mn;
      if (delta == 0) return '{v, v, v};
      if (r == mx) begin
         if (g >= b) begin sec = SEC0; diff = g - b; end
         else begin sec = SEC5; diff = delta - (b - g); end
      end else if (g == mx) begin
         if (b >= r) begin sec = SEC2; diff = b - r; end
         else begin sec = SEC1; diff = delta - (r - b); end
      end else begin
         if (r >= g) begin sec = SEC4; diff = r - g; end
         else begin sec = SEC3; diff = delta - (g - r); end
      end
      s = ({delta, {FB{1'b0}}}) / mx;
      f = ({diff, {FB{1'b0}}}) / delta;
      t1 = (1 << FB) - s;
      sf = s * f;
      sfn = s * ((1 << FB) - f);
      t2 = (1 << FB) - (sf >> FB);
      t3 = (1 << FB) - (sfn >> FB);
      c1 = scale_value(v, t1);
      c2 = scale_value(v, t2);
      c3 = scale_value(v, t3);
      case (sec)
         SEC0: p = '{v, c3, c1};
         SEC1: p = '{c2, v, c1};
         SEC2: p = '{c1, v, c3};
         SEC3: p = '{c1, c2, v};
         SEC4: p = '{c3, c1, v};
         default: p = '{v, c1, c2};
      endcase
      return p;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 3);
   endfunction

   // offer one request, predict its result once accepted
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] v, bit fixed, pixel_type fx);
      pixel_type p;
      req_valid <= 1'b1;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      req_target_value <= v;
      do @(posedge clock); while (req_stall);
      p = replace_value(r, g, b, v);
      if (fixed && p != fx) begin
         n_mismatch++;
         if (n_mismatch <= 10)
            $display("predictor disagrees on fixed row %0d %0d %0d %0d", r, g, b, v);
      end
      pixel_q.push_back(fixed ? fx : p);
      n_sent++;
   endtask

   task automatic send_random(bit gaps);
      logic [7:0] r, g, b, v;
      int k, gap;
      k = $urandom_range(0, 9);
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      v = 8'($urandom);
      // bias toward ties and gray to hit sector edges
      if (k == 0) g = r;
      else if (k == 1) b = g;
      else if (k == 2) begin g = r; b = r; end
      else if (k == 3) b = r;
      send_pixel(r, g, b, v, 1'b0, '0);
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_target_value = '0;
      n_mismatch = 0;
      n_checked = 0;
      n_sent = 0;
      stim_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < N_DIRECTED; i++)
         send_pixel(dir_r[i], dir_g[i], dir_b[i], dir_v[i], dir_fixed[i], dir_exp[i]);
      req_valid <= 1'b0;
      // sender pauses until the pipe drains
      while (pixel_q.size() != 0) @(posedge clock);
      for (i = 0; i < N_RANDOM; i++)
         send_random(i > 300 && i < 1500);
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver stall, with one long hold-off while requests keep coming
   initial begin
      int gap;
      rsp_stall = 1'b0;
      wait (n_sent > 100);
      @(posedge clock);
      rsp_stall <= 1'b1;
      repeat (200) @(posedge clock);
      rsp_stall <= 1'b0;
      forever begin
         if (n_sent > 1500) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            gap = pick_gap();
            rsp_stall <= (gap > 0);
            repeat (gap > 0 ? gap : 1) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_red_out, rsp_green_out, rsp_blue_out};
         if (pixel_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
               $display("unexpected result %0d %0d %0d", got.red, got.green, got.blue);
         end else begin
            want = pixel_q.pop_front();
            n_checked++;
            if (got != want) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           want.red, want.green, want.blue,
                           got.red, got.green, got.blue);
            end
         end
      end
   end

   initial begin
      int stuck;
      stuck = 0;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck = 0;
         else stuck++;
         if (stim_done && pixel_q.size() == 0) begin
            idle_cycles++;
            if (idle_cycles > 2 * LATENCY) begin
               $display("checked %0d pixels incl. gray, ties, all sectors and extremes",
                        n_checked);
               $display("stalls and gaps on both sides, one long output hold-off");
               if (n_mismatch == 0) $display("hsv_value_replace test passed");
               else $display("hsv_value_replace test failed");
               $finish;
            end
         end else if (stuck > STUCK_LIMIT) begin
            $display("hsv_value_replace test failed");
            $finish;
         end
      end
   end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/hvr_pkg.sv
rtl/core/hvr_front.sv
rtl/core/hvr_queue.sv
rtl/core/hvr_back.sv
rtl/core/hsv_value_replace.sv
tb/hsv_value_replace_tb.sv
